// ===== hdl/threshold_best_profit_lookup_top_macros.svh =====
// assertion helpers used by tbpl_ctrl
`ifndef THRESHOLD_BEST_PROFIT_LOOKUP_TOP_MACROS_SVH
`define THRESHOLD_BEST_PROFIT_LOOKUP_TOP_MACROS_SVH

// same-cycle implication
`define TBPL_ASSERT_IMPL(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tbpl assertion failed");

// next-cycle implication
`define TBPL_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tbpl assertion failed");

`endif

// ===== hdl/tbpl_pkg.sv =====
package tbpl_pkg;

    localparam int MAX_JOBS_DEFAULT = 256;
    localparam int FIELD_W          = 20;
    localparam int TOTAL_W          = 32;
    localparam int REQ_W            = 2;

    typedef enum logic [REQ_W-1:0] {
        REQ_CLEAR = 2'd0,
        REQ_ADD   = 2'd1,
        REQ_QUERY = 2'd2,
        REQ_NONE  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SUM,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [FIELD_W-1:0] job_difficulty;
        logic [FIELD_W-1:0] job_profit;
        logic [FIELD_W-1:0] worker_ability;
    } in_t;

    typedef struct packed {
        logic               status;
        logic [FIELD_W-1:0] worker_profit;
        logic [TOTAL_W-1:0] running_total;
    } out_t;

    // handshake between the controller and the output register
    typedef struct packed {
        logic valid;
        out_t data;
    } res_t;

endpackage

// ===== hdl/tbpl_ram.sv =====
module tbpl_ram #(
    parameter int WIDTH  = 40,
    parameter int DEPTH  = 256,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/tbpl_ctrl.sv =====
`include "threshold_best_profit_lookup_top_macros.svh"

module tbpl_ctrl #(
    parameter int MAX_JOBS = tbpl_pkg::MAX_JOBS_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tbpl_pkg::in_t  s_data,
    output tbpl_pkg::res_t res,
    input  logic           res_ready
);

    localparam int ADDR_W  = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
    localparam int CNT_W   = $clog2(MAX_JOBS + 1);
    localparam int FIELD_W = tbpl_pkg::FIELD_W;
    localparam int TOTAL_W = tbpl_pkg::TOTAL_W;
    localparam int ENTRY_W = 2 * FIELD_W;

    tbpl_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]   count_reg, count_next;
    logic [CNT_W-1:0]   idx_reg, idx_next;
    logic [FIELD_W-1:0] best_reg, best_next;
    logic [FIELD_W-1:0] ability_reg, ability_next;
    logic [TOTAL_W-1:0] total_reg, total_next;
    logic               status_reg, status_next;

    logic               accept;
    logic               full;
    logic               issue;
    logic               wr_en;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] rd_data;
    logic [FIELD_W-1:0] rd_diff;
    logic [FIELD_W-1:0] rd_prof;
    logic [TOTAL_W:0]   sum;
    tbpl_pkg::req_t     req;

    assign req     = tbpl_pkg::req_t'(s_data.req_type);
    assign accept  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(MAX_JOBS));
    assign rd_diff = rd_data[ENTRY_W-1:FIELD_W];
    assign rd_prof = rd_data[FIELD_W-1:0];
    assign sum     = {1'b0, total_reg} + {{(TOTAL_W + 1 - FIELD_W){1'b0}}, best_reg};

    tbpl_ram #(
        .WIDTH  (ENTRY_W),
        .DEPTH  (MAX_JOBS),
        .ADDR_W (ADDR_W)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (count_reg[ADDR_W-1:0]),
        .wr_data ({s_data.job_difficulty, s_data.job_profit}),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tbpl_pkg::ST_IDLE: begin
                if (accept) begin
                    if (req == tbpl_pkg::REQ_QUERY && count_reg != '0) begin
                        state_next = tbpl_pkg::ST_SCAN;
                    end else begin
                        state_next = tbpl_pkg::ST_RESP;
                    end
                end
            end
            tbpl_pkg::ST_SCAN: begin
                if (idx_reg == count_reg) begin
                    state_next = tbpl_pkg::ST_SUM;
                end
            end
            tbpl_pkg::ST_SUM: begin
                state_next = tbpl_pkg::ST_RESP;
            end
            tbpl_pkg::ST_RESP: begin
                if (res_ready) begin
                    state_next = tbpl_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = tbpl_pkg::ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb begin
        s_ready                = 1'b0;
        res.valid              = 1'b0;
        res.data.status        = status_reg;
        res.data.worker_profit = best_reg;
        res.data.running_total = total_reg;
        issue                  = 1'b0;
        wr_en                  = 1'b0;
        rd_en                  = 1'b0;
        rd_addr                = idx_reg[ADDR_W-1:0];
        unique case (state_reg)
            tbpl_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                rd_addr = '0;
                wr_en   = s_valid && (req == tbpl_pkg::REQ_ADD) && !full;
                rd_en   = s_valid && (req == tbpl_pkg::REQ_QUERY);
            end
            tbpl_pkg::ST_SCAN: begin
                issue = (idx_reg != count_reg);
                rd_en = issue;
            end
            tbpl_pkg::ST_SUM: begin
            end
            tbpl_pkg::ST_RESP: begin
                res.valid = 1'b1;
            end
            default: begin
            end
        endcase
    end

    // datapath
    always_comb begin
        count_next   = count_reg;
        idx_next     = idx_reg;
        best_next    = best_reg;
        ability_next = ability_reg;
        total_next   = total_reg;
        status_next  = status_reg;
        if (state_reg == tbpl_pkg::ST_IDLE && accept) begin
            best_next   = '0;
            status_next = 1'b0;
            case (req)
                tbpl_pkg::REQ_CLEAR: begin
                    count_next = '0;
                    total_next = '0;
                end
                tbpl_pkg::REQ_ADD: begin
                    if (full) begin
                        status_next = 1'b1;
                    end else begin
                        count_next = count_reg + CNT_W'(1);
                    end
                end
                tbpl_pkg::REQ_QUERY: begin
                    ability_next = s_data.worker_ability;
                    idx_next     = CNT_W'(1);
                end
                default: begin
                end
            endcase
        end
        if (state_reg == tbpl_pkg::ST_SCAN) begin
            if (rd_diff <= ability_reg && rd_prof > best_reg) begin
                best_next = rd_prof;
            end
            if (issue) begin
                idx_next = idx_reg + CNT_W'(1);
            end
        end
        if (state_reg == tbpl_pkg::ST_SUM) begin
            total_next = sum[TOTAL_W] ? '1 : sum[TOTAL_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tbpl_pkg::ST_IDLE;
            count_reg <= '0;
            total_reg <= '0;
        end else begin
            state_reg <= state_next;
            count_reg <= count_next;
            total_reg <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg     <= idx_next;
        best_reg    <= best_next;
        ability_reg <= ability_next;
        status_reg  <= status_next;
    end

    `TBPL_ASSERT_IMPL(a_count_bound, aclk, aresetn, 1'b1, count_reg <= CNT_W'(MAX_JOBS))
    `TBPL_ASSERT_IMPL(a_write_idle, aclk, aresetn, wr_en, state_reg == tbpl_pkg::ST_IDLE)
    `TBPL_ASSERT_IMPL(a_scan_idx, aclk, aresetn, state_reg == tbpl_pkg::ST_SCAN, idx_reg != '0 && idx_reg <= count_reg)
    `TBPL_ASSERT_NEXT(a_best_grows, aclk, aresetn, state_reg == tbpl_pkg::ST_SCAN, best_reg >= $past(best_reg))

endmodule

// ===== hdl/threshold_best_profit_lookup_top.sv =====
// job table with best-profit lookup for workers and a saturating running total
// input channel s_valid/s_ready/s_data carries one request per transaction:
// clear the table and total, add a job, or query with a worker ability
// result channel m_valid/m_ready/m_data returns one result per request:
// status (table full on add), worker profit and the running total
// clear, add and the unused code go from idle straight to the result state and
// raise m_valid once the result enters the output register; a query scans the
// stored jobs through the table ram, one entry per cycle, then passes the sum
// and result states (an empty table skips the scan); one request is in work at
// a time: the next is taken once back in idle; the ram scan sets the rate
// the result sits in an output register, so the next request is taken
// while an earlier result still waits for m_ready
// a stalled receiver holds the result; once the controller has its next result
// ready and the output register is still full, s_ready stays low
// reset (aresetn low, synchronous) empties the table and zeroes the total;
// no clearing pass is needed, the table is tracked by its entry count
module threshold_best_profit_lookup_top #(
    parameter int MAX_JOBS = tbpl_pkg::MAX_JOBS_DEFAULT
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  tbpl_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output tbpl_pkg::out_t m_data
);

    tbpl_pkg::res_t res;
    logic           res_ready;
    logic           m_valid_reg, m_valid_next;
    tbpl_pkg::out_t m_data_reg, m_data_next;

    tbpl_ctrl #(
        .MAX_JOBS (MAX_JOBS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .res       (res),
        .res_ready (res_ready)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (res.valid && res_ready) begin
            m_valid_next = 1'b1;
            m_data_next  = res.data;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
